FILE: src/hmb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hmb_pkg
// Shared types and constants of the handheld memory bus: memory map
// boundaries, I/O register addresses, action codes and sequencer states.
// ----------------------------------------------------------------------------
package hmb_pkg;

  // Memory map geometry.
  localparam int unsigned AddrWidth = 16;
  localparam int unsigned DataWidth = 8;
  localparam int unsigned MemDepth  = 65536;

  // Default number of bytes moved by one OAM DMA transfer.
  localparam int unsigned DmaLengthDefault = 160;

  // Region boundaries.
  localparam logic [15:0] ROM_LAST      = 16'h7FFF;
  localparam logic [15:0] UNUSED_FIRST  = 16'hFEA0;
  localparam logic [15:0] UNUSED_LAST   = 16'hFEFF;
  localparam logic [15:0] ECHO_HI_FIRST = 16'hE000;
  localparam logic [15:0] ECHO_HI_LAST  = 16'hFDFF;
  localparam logic [15:0] ECHO_LO_FIRST = 16'hC000;
  localparam logic [15:0] ECHO_LO_LAST  = 16'hDDFF;
  localparam logic [15:0] ECHO_OFFSET   = 16'h2000;
  localparam logic [7:0]  OAM_PAGE      = 8'hFE;

  // I/O register addresses.
  localparam logic [15:0] ADDR_P1   = 16'hFF00;
  localparam logic [15:0] ADDR_DIV  = 16'hFF04;
  localparam logic [15:0] ADDR_IF   = 16'hFF0F;
  localparam logic [15:0] ADDR_LCDC = 16'hFF40;
  localparam logic [15:0] ADDR_DMA  = 16'hFF46;

  // Register bit masks.
  localparam logic [7:0] P1_KEEP_MASK = 8'b11001111;
  localparam logic [7:0] IF_SET_MASK  = 8'b11100000;

  // Action codes of a request word.
  typedef enum logic [1:0] {
    ACT_READ      = 2'd0,
    ACT_BUS_WRITE = 2'd1,
    ACT_RAW_WRITE = 2'd2
  } action_e;

  // What a read-modify-write pass does with the old byte.
  typedef enum logic [1:0] {
    KIND_PLAIN,
    KIND_P1,
    KIND_LCDC
  } kind_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MIRROR,
    S_DMA,
    S_RESULT
  } state_e;

endpackage
`default_nettype wire

FILE: src/hmb_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hmb_req_if
// Request channel of the memory bus: action, address and write byte.
// ----------------------------------------------------------------------------
interface hmb_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] address;
  logic [7:0]  write_data;

  modport source (output valid, action, address, write_data, input ready);
  modport sink   (input valid, action, address, write_data, output ready);
endinterface
`default_nettype wire

FILE: src/hmb_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hmb_rsp_if
// Response channel of the memory bus: stored byte and PPU pulses.
// ----------------------------------------------------------------------------
interface hmb_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       ppu_enable;
  logic       ppu_disable;

  modport source (output valid, read_data, ppu_enable, ppu_disable, input ready);
  modport sink   (input valid, read_data, ppu_enable, ppu_disable, output ready);
endinterface
`default_nettype wire

FILE: src/hmb_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hmb_ram
// Generic simple dual-port RAM: one write port, one read port with the
// read data registered.
// ----------------------------------------------------------------------------
module hmb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

FILE: src/handheld_memory_bus_with_oam_dma.sv
`default_nettype none
// ----------------------------------------------------------------------------
// handheld_memory_bus_with_oam_dma
// 64K byte memory map with bus write rules, echo RAM mirroring and OAM DMA.
// ----------------------------------------------------------------------------
// Each request word reads, bus-writes or raw-writes one byte of a 64K byte
// memory map held in a single simple dual-port RAM, and returns one response
// word with the byte stored at the address afterwards. A request is taken
// only while the sequencer is idle; the response waits in an output register,
// so the next request can be taken before the response is collected. Since
// the RAM read data is registered, a read, a write to ROM or the unusable
// area, and a joypad or LCDC write (read-modify-write) pass through the read
// state; an echo RAM write makes its second store in the mirror state; a plain
// write goes straight to the result state; and a write to the DMA register
// passes through the DMA state, where the copy streams one byte per cycle
// through the RAM's read and write ports. Memory contents are undefined after
// reset; load them with raw writes before reading them.
module handheld_memory_bus_with_oam_dma #(
  parameter int unsigned DmaLength = hmb_pkg::DmaLengthDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hmb_req_if.sink   req_i,
  hmb_rsp_if.source rsp_o
);

  localparam int unsigned CntW = $clog2(DmaLength + 1);

  hmb_pkg::state_e state_q, state_d;
  hmb_pkg::kind_e  kind_q, kind_d;
  logic [15:0]     addr_q, addr_d;
  logic [7:0]      data_q, data_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            dvalid_q, dvalid_d;
  logic [7:0]      res_q, res_d;
  logic            en_q, en_d;
  logic            dis_q, dis_d;

  logic            rsp_valid_q;
  logic [7:0]      rsp_data_q;
  logic            rsp_en_q;
  logic            rsp_dis_q;
  logic            out_load;

  logic            ram_we;
  logic [15:0]     ram_waddr;
  logic [7:0]      ram_wdata;
  logic [15:0]     ram_raddr;
  logic [7:0]      ram_rdata;

  logic [15:0]     in_addr;
  logic [7:0]      in_data;
  logic            in_ignored;
  logic [7:0]      bus_wval;
  logic [7:0]      p1_new;

  // Byte memory of the whole map.
  hmb_ram #(
    .Width(hmb_pkg::DataWidth),
    .Depth(hmb_pkg::MemDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Request decode.
  assign in_addr    = req_i.address;
  assign in_data    = req_i.write_data;
  assign in_ignored = (in_addr <= hmb_pkg::ROM_LAST) ||
                      ((in_addr >= hmb_pkg::UNUSED_FIRST) &&
                       (in_addr <= hmb_pkg::UNUSED_LAST));

  // Stored value of a write-only bus write: DIV clears, IF sets its top bits.
  always_comb begin
    if (in_addr == hmb_pkg::ADDR_DIV) begin
      bus_wval = '0;
    end else if (in_addr == hmb_pkg::ADDR_IF) begin
      bus_wval = in_data | hmb_pkg::IF_SET_MASK;
    end else begin
      bus_wval = in_data;
    end
  end

  // Joypad merge: only bits 4 and 5 take the written value.
  assign p1_new = (ram_rdata & hmb_pkg::P1_KEEP_MASK) |
                  (data_q & ~hmb_pkg::P1_KEEP_MASK);

  assign req_i.ready = (state_q == hmb_pkg::S_IDLE);

  // Sequencer: next state, RAM access and result capture.
  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    addr_d    = addr_q;
    data_d    = data_q;
    cnt_d     = cnt_q;
    dvalid_d  = dvalid_q;
    res_d     = res_q;
    en_d      = en_q;
    dis_d     = dis_q;
    ram_we    = 1'b0;
    ram_waddr = in_addr;
    ram_wdata = in_data;
    ram_raddr = in_addr;
    out_load  = 1'b0;

    case (state_q)
      hmb_pkg::S_IDLE: begin
        if (req_i.valid) begin
          addr_d = in_addr;
          data_d = in_data;
          kind_d = hmb_pkg::KIND_PLAIN;
          en_d   = 1'b0;
          dis_d  = 1'b0;
          case (req_i.action)
            hmb_pkg::ACT_RAW_WRITE: begin
              ram_we  = 1'b1;
              res_d   = in_data;
              state_d = hmb_pkg::S_RESULT;
            end
            hmb_pkg::ACT_BUS_WRITE: begin
              if (in_ignored) begin
                state_d = hmb_pkg::S_READ;
              end else if (in_addr == hmb_pkg::ADDR_P1) begin
                kind_d  = hmb_pkg::KIND_P1;
                state_d = hmb_pkg::S_READ;
              end else if (in_addr == hmb_pkg::ADDR_LCDC) begin
                kind_d  = hmb_pkg::KIND_LCDC;
                state_d = hmb_pkg::S_READ;
              end else begin
                ram_we    = 1'b1;
                ram_wdata = bus_wval;
                res_d     = bus_wval;
                if (in_addr == hmb_pkg::ADDR_DMA) begin
                  cnt_d    = '0;
                  dvalid_d = 1'b0;
                  state_d  = hmb_pkg::S_DMA;
                end else if ((in_addr >= hmb_pkg::ECHO_HI_FIRST) &&
                             (in_addr <= hmb_pkg::ECHO_HI_LAST)) begin
                  addr_d  = in_addr - hmb_pkg::ECHO_OFFSET;
                  state_d = hmb_pkg::S_MIRROR;
                end else if ((in_addr >= hmb_pkg::ECHO_LO_FIRST) &&
                             (in_addr <= hmb_pkg::ECHO_LO_LAST)) begin
                  addr_d  = in_addr + hmb_pkg::ECHO_OFFSET;
                  state_d = hmb_pkg::S_MIRROR;
                end else begin
                  state_d = hmb_pkg::S_RESULT;
                end
              end
            end
            default: begin
              state_d = hmb_pkg::S_READ;
            end
          endcase
        end
      end

      // Old byte is on the read port; modify and write back if needed.
      hmb_pkg::S_READ: begin
        ram_waddr = addr_q;
        ram_raddr = addr_q;
        case (kind_q)
          hmb_pkg::KIND_P1: begin
            ram_we    = 1'b1;
            ram_wdata = p1_new;
            res_d     = p1_new;
          end
          hmb_pkg::KIND_LCDC: begin
            ram_we    = 1'b1;
            ram_wdata = data_q;
            res_d     = data_q;
            en_d      = data_q[7] & ~ram_rdata[7];
            dis_d     = ~data_q[7] & ram_rdata[7];
          end
          default: begin
            res_d = ram_rdata;
          end
        endcase
        state_d = hmb_pkg::S_RESULT;
      end

      // Second store of an echo RAM write.
      hmb_pkg::S_MIRROR: begin
        ram_we    = 1'b1;
        ram_waddr = addr_q;
        ram_wdata = data_q;
        state_d   = hmb_pkg::S_RESULT;
      end

      // OAM copy: read byte i while writing byte i-1.
      hmb_pkg::S_DMA: begin
        ram_we    = dvalid_q;
        ram_waddr = {hmb_pkg::OAM_PAGE, 8'(cnt_q - CntW'(1))};
        ram_wdata = ram_rdata;
        ram_raddr = {data_q, 8'(cnt_q)};
        if (cnt_q != CntW'(DmaLength)) begin
          cnt_d    = cnt_q + CntW'(1);
          dvalid_d = 1'b1;
        end else begin
          dvalid_d = 1'b0;
          state_d  = hmb_pkg::S_RESULT;
        end
      end

      // Hand the result to the output register once it is free.
      hmb_pkg::S_RESULT: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = hmb_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = hmb_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hmb_pkg::S_IDLE;
      dvalid_q    <= 1'b0;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      dvalid_q <= dvalid_d;
      cnt_q    <= cnt_d;
      if (out_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    addr_q <= addr_d;
    data_q <= data_d;
    res_q  <= res_d;
    en_q   <= en_d;
    dis_q  <= dis_d;
    if (out_load) begin
      rsp_data_q <= res_q;
      rsp_en_q   <= en_q;
      rsp_dis_q  <= dis_q;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.read_data   = rsp_data_q;
  assign rsp_o.ppu_enable  = rsp_en_q;
  assign rsp_o.ppu_disable = rsp_dis_q;

  // An LCDC write raises at most one of the two pulses.
  a_pulse_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !(rsp_o.ppu_enable && rsp_o.ppu_disable))
    else $error("PPU enable and disable pulses raised together");

  // The copy counter never runs past the transfer length.
  a_dma_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hmb_pkg::S_DMA) |-> (cnt_q <= CntW'(DmaLength)))
    else $error("DMA counter beyond transfer length");

  // DMA stores land in the OAM page only.
  a_dma_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == hmb_pkg::S_DMA) && ram_we) |-> (ram_waddr[15:8] == hmb_pkg::OAM_PAGE))
    else $error("DMA store outside OAM");

  // An accepted request always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> (state_q != hmb_pkg::S_IDLE))
    else $error("Request accepted without starting work");

  // A response is loaded only when the output register is free or draining.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!rsp_valid_q || rsp_o.ready))
    else $error("Pending response overwritten");

endmodule
`default_nettype wire

FILE: sim/tb_handheld_memory_bus_with_oam_dma.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_handheld_memory_bus_with_oam_dma
// Self-checking bench for the handheld memory bus. It covers reads, bus writes
// under the memory map rules, raw writes and OAM DMA. Every accepted request
// word updates a shadow copy of the 64K map, and the response word that it
// should return is queued. Each response word is checked against the oldest
// queued one. Stimulus only reads bytes that have been written before.
// ----------------------------------------------------------------------------
module tb_handheld_memory_bus_with_oam_dma;

  localparam int unsigned DmaLen     = hmb_pkg::DmaLengthDefault;
  localparam int unsigned TotalItems = 1400;
  localparam logic [1:0]  ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  act;
    logic [15:0] addr;
    logic [7:0]  data;
  } access_t;

  typedef struct packed {
    logic [15:0] addr;
    logic [7:0]  read_data;
    logic        ppu_enable;
    logic        ppu_disable;
  } bus_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  hmb_req_if req_bus ();
  hmb_rsp_if rsp_bus ();

  handheld_memory_bus_with_oam_dma #(
    .DmaLength(DmaLen)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  always #5 clk_i = ~clk_i;

  // Request words waiting to be driven, and responses the map should return.
  access_t     access_q[$];
  bus_result_t access_result_q[$];

  // Shadow of the memory map, updated when a request word is accepted.
  logic [7:0]  shadow_mem [65536];

  // Which bytes the stimulus has already written, tracked ahead of the driver.
  bit          loaded_map [65536];
  logic [15:0] loaded_list[$];

  int unsigned total_items    = 0;
  int unsigned accepted_count = 0;
  int unsigned error_count    = 0;

  task automatic log_mismatch(string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    error_count++;
  endtask

  // Idle percentage of the sender or the receiver in the current phase.
  function automatic int unsigned idle_pct(bit sender);
    if (accepted_count < total_items / 3) return sender ? 22 : 72;
    if (accepted_count < 2 * total_items / 3) return sender ? 72 : 22;
    return 0;
  endfunction

  function automatic bit in_rom_or_unused(logic [15:0] a);
    return a <= hmb_pkg::ROM_LAST ||
           (a >= hmb_pkg::UNUSED_FIRST && a <= hmb_pkg::UNUSED_LAST);
  endfunction

  function automatic bit in_echo_hi(logic [15:0] a);
    return a >= hmb_pkg::ECHO_HI_FIRST && a <= hmb_pkg::ECHO_HI_LAST;
  endfunction

  function automatic bit in_echo_lo(logic [15:0] a);
    return a >= hmb_pkg::ECHO_LO_FIRST && a <= hmb_pkg::ECHO_LO_LAST;
  endfunction

  // Apply one access to the shadow map and queue the response it causes.
  task automatic apply_access(logic [1:0] act, logic [15:0] a, logic [7:0] d);
    logic        en;
    logic        dis;
    logic [15:0] src;
    en  = 1'b0;
    dis = 1'b0;
    if (act == hmb_pkg::ACT_BUS_WRITE) begin
      if (in_rom_or_unused(a)) begin
        // Ignored: the stored byte is only read back.
      end else if (a == hmb_pkg::ADDR_P1) begin
        shadow_mem[a] = (shadow_mem[a] & hmb_pkg::P1_KEEP_MASK) |
                        (d & ~hmb_pkg::P1_KEEP_MASK);
      end else begin
        if (a == hmb_pkg::ADDR_LCDC) begin
          en  = d[7] & ~shadow_mem[a][7];
          dis = ~d[7] & shadow_mem[a][7];
        end
        shadow_mem[a] = d;
        // OAM DMA copies in rising order, so an overlapping source sees new bytes.
        if (a == hmb_pkg::ADDR_DMA) begin
          for (int i = 0; i < DmaLen && i < 256; i++) begin
            src = {d, 8'h00} + 16'(i);
            shadow_mem[{hmb_pkg::OAM_PAGE, 8'h00} + 16'(i)] = shadow_mem[src];
          end
        end
        if (in_echo_hi(a)) shadow_mem[a - hmb_pkg::ECHO_OFFSET] = d;
        else if (in_echo_lo(a)) shadow_mem[a + hmb_pkg::ECHO_OFFSET] = d;
        if (a == hmb_pkg::ADDR_IF) shadow_mem[a] = shadow_mem[a] | hmb_pkg::IF_SET_MASK;
        if (a == hmb_pkg::ADDR_DIV) shadow_mem[a] = 8'h00;
      end
    end else if (act == hmb_pkg::ACT_RAW_WRITE) begin
      shadow_mem[a] = d;
    end
    access_result_q.push_back('{addr: a, read_data: shadow_mem[a], ppu_enable: en,
                                ppu_disable: dis});
  endtask

  function automatic void mark_loaded(logic [15:0] a);
    if (!loaded_map[a]) begin
      loaded_map[a] = 1'b1;
      loaded_list.push_back(a);
    end
  endfunction

  // An access is allowed only if it reads no byte that was never written.
  function automatic bit access_is_legal(logic [1:0] act, logic [15:0] a, logic [7:0] d);
    logic [15:0] src;
    if (act == hmb_pkg::ACT_RAW_WRITE) return 1'b1;
    if (act != hmb_pkg::ACT_BUS_WRITE) return loaded_map[a];
    if (in_rom_or_unused(a) || a == hmb_pkg::ADDR_P1 || a == hmb_pkg::ADDR_LCDC)
      return loaded_map[a];
    if (a == hmb_pkg::ADDR_DMA) begin
      for (int i = 0; i < DmaLen; i++) begin
        src = {d, 8'h00} + 16'(i);
        if (src != hmb_pkg::ADDR_DMA && !loaded_map[src]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Queue one request word and note which bytes it leaves written.
  function automatic void queue_access(logic [1:0] act, logic [15:0] a, logic [7:0] d);
    if (act == hmb_pkg::ACT_RAW_WRITE) begin
      mark_loaded(a);
    end else if (act == hmb_pkg::ACT_BUS_WRITE && !in_rom_or_unused(a) &&
                 a != hmb_pkg::ADDR_P1) begin
      mark_loaded(a);
      if (a == hmb_pkg::ADDR_DMA)
        for (int i = 0; i < DmaLen; i++)
          mark_loaded({hmb_pkg::OAM_PAGE, 8'h00} + 16'(i));
      if (in_echo_hi(a)) mark_loaded(a - hmb_pkg::ECHO_OFFSET);
      else if (in_echo_lo(a)) mark_loaded(a + hmb_pkg::ECHO_OFFSET);
    end
    access_q.push_back('{act: act, addr: a, data: d});
  endfunction

  // Address mix: reuse, fully random, and the interesting regions and borders.
  function automatic logic [15:0] pick_address();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 35 && loaded_list.size() > 0)
      return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    if (sel < 50) return 16'($urandom);
    if (sel < 60) return 16'($urandom_range(0, hmb_pkg::ROM_LAST));
    if (sel < 72)
      return 16'($urandom_range(hmb_pkg::ECHO_LO_FIRST, hmb_pkg::ECHO_HI_LAST));
    if (sel < 78) return {hmb_pkg::OAM_PAGE, 8'($urandom)};
    if (sel < 88) return {8'hFF, 8'($urandom)};
    case ($urandom_range(0, 12))
      0: return hmb_pkg::ROM_LAST;
      1: return hmb_pkg::ROM_LAST + 16'd1;
      2: return hmb_pkg::ECHO_LO_FIRST;
      3: return hmb_pkg::ECHO_LO_LAST;
      4: return hmb_pkg::ECHO_LO_LAST + 16'd1;
      5: return hmb_pkg::ECHO_HI_FIRST;
      6: return hmb_pkg::ECHO_HI_LAST;
      7: return {hmb_pkg::OAM_PAGE, 8'h00};
      8: return hmb_pkg::UNUSED_FIRST - 16'd1;
      9: return hmb_pkg::UNUSED_FIRST;
      10: return hmb_pkg::UNUSED_LAST;
      11: return hmb_pkg::ADDR_P1;
      default: return 16'hFFFF;
    endcase
  endfunction

  // Driver: one request word per handshake, with random idle cycles.
  access_t nxt;
  bit      took;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
    end else begin
      took = req_bus.valid && req_bus.ready;
      if (took) begin
        apply_access(req_bus.action, req_bus.address, req_bus.write_data);
        accepted_count++;
      end
      if (!req_bus.valid || took) begin
        if (access_q.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
          nxt = access_q.pop_front();
          req_bus.valid      <= 1'b1;
          req_bus.action     <= nxt.act;
          req_bus.address    <= nxt.addr;
          req_bus.write_data <= nxt.data;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each response word with the oldest one queued.
  bus_result_t want;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (access_result_q.size() == 0) begin
          log_mismatch($sformatf("response word %02h with no access pending",
                                 rsp_bus.read_data));
        end else begin
          want = access_result_q.pop_front();
          if (rsp_bus.read_data !== want.read_data)
            log_mismatch($sformatf("addr %04h read_data %02h, want %02h", want.addr,
                                   rsp_bus.read_data, want.read_data));
          if (rsp_bus.ppu_enable !== want.ppu_enable)
            log_mismatch($sformatf("addr %04h ppu_enable %b, want %b", want.addr,
                                   rsp_bus.ppu_enable, want.ppu_enable));
          if (rsp_bus.ppu_disable !== want.ppu_disable)
            log_mismatch($sformatf("addr %04h ppu_disable %b, want %b", want.addr,
                                   rsp_bus.ppu_disable, want.ppu_disable));
        end
      end
      rsp_bus.ready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
    end
  end

  // Stimulus, reset and end of run.
  initial begin : stimulus
    logic [1:0]  act;
    logic [15:0] a;
    logic [7:0]  d;
    logic [7:0]  fill_page;
    int unsigned sel;

    req_bus.valid      = 1'b0;
    req_bus.action     = hmb_pkg::ACT_READ;
    req_bus.address    = 16'h0000;
    req_bus.write_data = 8'h00;
    rsp_bus.ready      = 1'b0;

    // Extremes of the map and the unused action code.
    queue_access(hmb_pkg::ACT_RAW_WRITE, 16'h0000, 8'h00);
    queue_access(hmb_pkg::ACT_RAW_WRITE, 16'hFFFF, 8'hFF);
    queue_access(hmb_pkg::ACT_READ, 16'h0000, 8'hFF);
    queue_access(ACT_UNUSED, 16'hFFFF, 8'h00);
    // Bus writes to ROM and to the unusable area are dropped; raw writes store.
    queue_access(hmb_pkg::ACT_RAW_WRITE, hmb_pkg::ROM_LAST, 8'hA5);
    queue_access(hmb_pkg::ACT_BUS_WRITE, hmb_pkg::ROM_LAST, 8'h5A);
    queue_access(hmb_pkg::ACT_RAW_WRITE, hmb_pkg::UNUSED_FIRST, 8'h3C);
    queue_access(hmb_pkg::ACT_BUS_WRITE, hmb_pkg::UNUSED_FIRST, 8'hC3);
    // Joypad keeps all but bits 4 and 5.
    queue_access(hmb_pkg::ACT_RAW_WRITE, hmb_pkg::ADDR_P1, 8'hC5);
    queue_access(hmb_pkg::ACT_BUS_WRITE, hmb_pkg::ADDR_P1, 8'h00);
    queue_access(hmb_pkg::ACT_BUS_WRITE, hmb_pkg::ADDR_P1, 8'hFF);
    // LCDC bit 7 rising, steady, then falling.
    queue_access(hmb_pkg::ACT_RAW_WRITE, hmb_pkg::ADDR_LCDC, 8'h00);
    queue_access(hmb_pkg::ACT_BUS_WRITE, hmb_pkg::ADDR_LCDC, 8'h80);
    queue_access(hmb_pkg::ACT_BUS_WRITE, hmb_pkg::ADDR_LCDC, 8'h91);
    queue_access(hmb_pkg::ACT_BUS_WRITE, hmb_pkg::ADDR_LCDC, 8'h00);
    // Divider clears, interrupt flags force their top bits.
    queue_access(hmb_pkg::ACT_BUS_WRITE, hmb_pkg::ADDR_DIV, 8'hFF);
    queue_access(hmb_pkg::ACT_BUS_WRITE, hmb_pkg::ADDR_IF, 8'h00);
    // Echo RAM borders in both directions, just past the low echo range, and just past ROM.
    queue_access(hmb_pkg::ACT_BUS_WRITE, hmb_pkg::ECHO_HI_FIRST, 8'h11);
    queue_access(hmb_pkg::ACT_READ, hmb_pkg::ECHO_LO_FIRST, 8'h00);
    queue_access(hmb_pkg::ACT_BUS_WRITE, hmb_pkg::ECHO_LO_LAST, 8'h44);
    queue_access(hmb_pkg::ACT_READ, hmb_pkg::ECHO_HI_LAST, 8'h00);
    queue_access(hmb_pkg::ACT_BUS_WRITE, hmb_pkg::ECHO_HI_LAST, 8'h22);
    queue_access(hmb_pkg::ACT_BUS_WRITE, hmb_pkg::ECHO_LO_FIRST, 8'h33);
    queue_access(hmb_pkg::ACT_BUS_WRITE, hmb_pkg::ECHO_LO_LAST + 16'd1, 8'h55);
    queue_access(hmb_pkg::ACT_BUS_WRITE, hmb_pkg::ROM_LAST + 16'd1, 8'h77);

    // Fill the first DmaLen bytes of one work RAM page through the bus so they
    // can feed OAM DMA, then copy from that page and from its echo.
    fill_page = 8'($urandom_range(hmb_pkg::ECHO_LO_FIRST >> 8,
                                  hmb_pkg::ECHO_LO_LAST >> 8));
    for (int i = 0; i < DmaLen; i++)
      queue_access(hmb_pkg::ACT_BUS_WRITE, {fill_page, 8'(i)}, 8'($urandom));
    queue_access(hmb_pkg::ACT_BUS_WRITE, hmb_pkg::ADDR_DMA, fill_page);
    queue_access(hmb_pkg::ACT_BUS_WRITE, hmb_pkg::ADDR_DMA, fill_page + 8'h20);

    // Random mix of reads, raw writes, bus writes, DMA and I/O registers.
    while (access_q.size() < TotalItems) begin
      sel = $urandom_range(0, 99);
      d   = 8'($urandom);
      if (sel < 25) begin
        act = ($urandom_range(0, 9) == 0) ? ACT_UNUSED : hmb_pkg::ACT_READ;
        a   = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
      end else if (sel < 45) begin
        act = hmb_pkg::ACT_RAW_WRITE;
        a   = pick_address();
      end else if (sel < 90) begin
        act = hmb_pkg::ACT_BUS_WRITE;
        a   = pick_address();
      end else if (sel < 94) begin
        act = hmb_pkg::ACT_BUS_WRITE;
        a   = hmb_pkg::ADDR_DMA;
        case ($urandom_range(0, 3))
          0: d = fill_page;
          1: d = fill_page + 8'h20;
          2: d = hmb_pkg::OAM_PAGE;
          default: d = 8'($urandom);
        endcase
        if (!access_is_legal(act, a, d)) d = fill_page;
      end else begin
        act = hmb_pkg::ACT_BUS_WRITE;
        case ($urandom_range(0, 3))
          0: a = hmb_pkg::ADDR_P1;
          1: a = hmb_pkg::ADDR_DIV;
          2: a = hmb_pkg::ADDR_IF;
          default: a = hmb_pkg::ADDR_LCDC;
        endcase
      end
      // A write that would read an unwritten byte becomes a raw write.
      if (!access_is_legal(act, a, d)) act = hmb_pkg::ACT_RAW_WRITE;
      queue_access(act, a, d);
    end
    total_items = access_q.size();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (access_q.size() != 0 || req_bus.valid || access_result_q.size() != 0)
      @(negedge clk_i);
    repeat (DmaLen + 10) @(posedge clk_i);

    if (access_result_q.size() != 0)
      log_mismatch($sformatf("%0d responses never arrived", access_result_q.size()));
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #(20_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: files.f
src/hmb_pkg.sv
src/hmb_req_if.sv
src/hmb_rsp_if.sv
src/hmb_ram.sv
src/handheld_memory_bus_with_oam_dma.sv
sim/tb_handheld_memory_bus_with_oam_dma.sv
